@@ rtl/core/tcmp_pkg.sv @@
// ----------------------------------------------------------------------------
// tcmp_pkg
// Types, constants and helper functions of the Tiger compression core.
// ----------------------------------------------------------------------------
package tcmp_pkg;

    typedef logic [63:0]      word_t;
    typedef logic [7:0][63:0] msg_t;
    typedef logic [2:0][63:0] chain_t;

    localparam word_t IV_A = 64'h0123456789ABCDEF;
    localparam word_t IV_B = 64'hFEDCBA9876543210;
    localparam word_t IV_C = 64'hF096A5B4C3B2E187;

    localparam word_t SCHED_K0 = 64'hA5A5A5A5A5A5A5A5;
    localparam word_t SCHED_K1 = 64'h0123456789ABCDEF;
    localparam int    SHL_AMT  = 19;
    localparam int    SHR_AMT  = 23;

    // seed string of the table construction, packed little-endian
    localparam msg_t SEED_MSG = {
        64'h6D6168694220696C, 64'h4520646E61206E6F,
        64'h737265646E412073, 64'h736F52207962202C,
        64'h6E6F6974636E7546, 64'h2068736148207765,
        64'h4E20747361462041, 64'h202D207265676954
    };

    // table address of lookup k (0..3 feed a, 4..7 feed b) for value c
    function automatic logic [9:0] lookup_addr(input logic [2:0] k, input word_t c);
        logic [9:0] a;
        begin
            case (k)
                3'd0:    a = {2'd0, c[7:0]};
                3'd1:    a = {2'd1, c[23:16]};
                3'd2:    a = {2'd2, c[39:32]};
                3'd3:    a = {2'd3, c[55:48]};
                3'd4:    a = {2'd3, c[15:8]};
                3'd5:    a = {2'd2, c[31:24]};
                3'd6:    a = {2'd1, c[47:40]};
                default: a = {2'd0, c[63:56]};
            endcase
            return a;
        end
    endfunction

    // multiply by 5, 7 or 9 for pass 0, 1 or 2
    function automatic word_t pass_mul(input word_t b, input logic [1:0] pass);
        word_t r;
        begin
            case (pass)
                2'd0:    r = (b << 2) + b;
                2'd1:    r = (b << 3) - b;
                default: r = (b << 3) + b;
            endcase
            return r;
        end
    endfunction

    // one step of the key schedule
    function automatic msg_t sched_step(input msg_t x, input logic [3:0] step);
        msg_t y;
        begin
            y = x;
            case (step)
                4'd0:    y[0] = x[0] - (x[7] ^ SCHED_K0);
                4'd1:    y[1] = x[1] ^ x[0];
                4'd2:    y[2] = x[2] + x[1];
                4'd3:    y[3] = x[3] - (x[2] ^ ((~x[1]) << SHL_AMT));
                4'd4:    y[4] = x[4] ^ x[3];
                4'd5:    y[5] = x[5] + x[4];
                4'd6:    y[6] = x[6] - (x[5] ^ ((~x[4]) >> SHR_AMT));
                4'd7:    y[7] = x[7] ^ x[6];
                4'd8:    y[0] = x[0] + x[7];
                4'd9:    y[1] = x[1] - (x[0] ^ ((~x[7]) << SHL_AMT));
                4'd10:   y[2] = x[2] ^ x[1];
                4'd11:   y[3] = x[3] + x[2];
                4'd12:   y[4] = x[4] - (x[3] ^ ((~x[2]) >> SHR_AMT));
                4'd13:   y[5] = x[5] ^ x[4];
                4'd14:   y[6] = x[6] + x[5];
                default: y[7] = x[7] - (x[6] ^ SCHED_K1);
            endcase
            return y;
        end
    endfunction

endpackage

@@ rtl/core/tiger_compression_core.sv @@
// ----------------------------------------------------------------------------
// tiger_compression_core
// Tiger compression function: 512-bit block into a 192-bit chaining value.
// ----------------------------------------------------------------------------
// After reset the core builds the four 256 x 64-bit S-box tables in an
// internal single-port RAM by the standard Tiger table construction: a fill
// sweep over all 1024 words, then 5120 row steps of byte-column swaps with a
// Tiger compression of the seed block every third step. During the build
// in_stall stays high. Afterwards each of the 24 rounds of a block performs
// its eight S-box lookups one after another because they share the one RAM
// read port, the two key schedules take one step per cycle, and the
// feed-forward and the return to idle for the next transfer follow. A block
// with start_req set restarts from the Tiger initial value; otherwise it
// chains on the previous result. The result sits in an output register, so
// the next block may be accepted while the result still waits.
// ----------------------------------------------------------------------------
module tiger_compression_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        start_req,
    input  logic [63:0] word0,
    input  logic [63:0] word1,
    input  logic [63:0] word2,
    input  logic [63:0] word3,
    input  logic [63:0] word4,
    input  logic [63:0] word5,
    input  logic [63:0] word6,
    input  logic [63:0] word7,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] hash_a,
    output logic [63:0] hash_b,
    output logic [63:0] hash_c
);

    localparam logic [3:0] ST_FILL  = 4'd0;
    localparam logic [3:0] ST_UNIT  = 4'd1;
    localparam logic [3:0] ST_RDP   = 4'd2;
    localparam logic [3:0] ST_WAITP = 4'd3;
    localparam logic [3:0] ST_COL   = 4'd4;
    localparam logic [3:0] ST_SWQ   = 4'd5;
    localparam logic [3:0] ST_WRP   = 4'd6;
    localparam logic [3:0] ST_IDLE  = 4'd7;
    localparam logic [3:0] ST_RXOR  = 4'd8;
    localparam logic [3:0] ST_RLOOK = 4'd9;
    localparam logic [3:0] ST_SCHED = 4'd10;
    localparam logic [3:0] ST_FF    = 4'd11;

    // control
    logic [3:0]  state_reg;
    logic        build_reg;
    logic [9:0]  fill_reg;
    logic [7:0]  row_reg;
    logic [1:0]  tbl_reg;
    logic [2:0]  pass_reg;
    logic [1:0]  sel_reg;
    logic [2:0]  col_reg;
    logic [4:0]  rnd_reg;
    logic [3:0]  lk_reg;
    logic [3:0]  sk_reg;
    logic        out_valid_reg;

    // datapath
    tcmp_pkg::chain_t cv_reg;
    tcmp_pkg::msg_t   x_reg;
    tcmp_pkg::word_t  ra_reg;
    tcmp_pkg::word_t  rb_reg;
    tcmp_pkg::word_t  rc_reg;
    tcmp_pkg::word_t  acc_a_reg;
    tcmp_pkg::word_t  acc_b_reg;
    tcmp_pkg::word_t  prow_reg;
    tcmp_pkg::word_t  hash_a_reg;
    tcmp_pkg::word_t  hash_b_reg;
    tcmp_pkg::word_t  hash_c_reg;

    // S-box RAM
    tcmp_pkg::word_t  sbox_mem [0:1023];
    tcmp_pkg::word_t  rdata_reg;
    logic [9:0]       mem_addr;
    logic             mem_we;
    tcmp_pkg::word_t  mem_wdata;

    logic [7:0]       col_idx;
    tcmp_pkg::word_t  col_mask;
    tcmp_pkg::word_t  q_new;
    tcmp_pkg::word_t  a_new;
    tcmp_pkg::word_t  b_new;
    logic             in_xfer;
    logic             last_unit;
    logic             out_load;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign hash_a    = hash_a_reg;
    assign hash_b    = hash_b_reg;
    assign hash_c    = hash_c_reg;

    assign col_idx   = cv_reg[sel_reg][{col_reg, 3'b000} +: 8];
    assign col_mask  = 64'hFF << {col_reg, 3'b000};
    assign q_new     = (rdata_reg & ~col_mask) | (prow_reg & col_mask);
    assign a_new     = ra_reg - acc_a_reg;
    assign b_new     = tcmp_pkg::pass_mul(rb_reg + (acc_b_reg ^ rdata_reg), rnd_reg[4:3]);
    assign last_unit = (pass_reg == 3'd4) && (row_reg == 8'hFF) && (tbl_reg == 2'd3);
    // load a new result once the output register is free or empties this cycle
    assign out_load  = (state_reg == ST_FF) && !build_reg && (!out_valid_reg || !out_stall);

    // RAM port select
    always_comb
    begin
        mem_addr  = {tbl_reg, row_reg};
        mem_we    = 1'b0;
        mem_wdata = prow_reg;
        case (state_reg)
            ST_FILL:
            begin
                mem_addr  = fill_reg;
                mem_we    = 1'b1;
                mem_wdata = {8{fill_reg[7:0]}};
            end
            ST_COL:  mem_addr = {tbl_reg, col_idx};
            ST_SWQ:
            begin
                mem_addr  = {tbl_reg, col_idx};
                mem_we    = 1'b1;
                mem_wdata = q_new;
            end
            ST_WRP:  mem_we = 1'b1;
            ST_RLOOK: mem_addr = tcmp_pkg::lookup_addr(lk_reg[2:0], rc_reg);
            default: mem_addr = {tbl_reg, row_reg};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sbox_mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= sbox_mem[mem_addr];
    end

    // sequencer and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            build_reg     <= 1'b1;
            fill_reg      <= '0;
            row_reg       <= '0;
            tbl_reg       <= '0;
            pass_reg      <= '0;
            sel_reg       <= 2'd2;
            col_reg       <= '0;
            rnd_reg       <= '0;
            lk_reg        <= '0;
            sk_reg        <= '0;
            out_valid_reg <= 1'b0;
            cv_reg        <= {tcmp_pkg::IV_C, tcmp_pkg::IV_B, tcmp_pkg::IV_A};
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_FILL:
                begin
                    fill_reg <= fill_reg + 10'd1;
                    if (fill_reg == 10'h3FF)
                    begin
                        state_reg <= ST_UNIT;
                    end
                end
                ST_UNIT:
                begin
                    if (sel_reg == 2'd2)
                    begin
                        // every third row step: compress the seed block
                        sel_reg   <= 2'd0;
                        ra_reg    <= cv_reg[0];
                        rb_reg    <= cv_reg[1];
                        rc_reg    <= cv_reg[2];
                        x_reg     <= tcmp_pkg::SEED_MSG;
                        rnd_reg   <= '0;
                        state_reg <= ST_RXOR;
                    end
                    else
                    begin
                        sel_reg   <= sel_reg + 2'd1;
                        state_reg <= ST_RDP;
                    end
                end
                ST_RDP:   state_reg <= ST_WAITP;
                ST_WAITP:
                begin
                    prow_reg  <= rdata_reg;
                    col_reg   <= '0;
                    state_reg <= ST_COL;
                end
                ST_COL:
                begin
                    if (col_idx == row_reg)
                    begin
                        // swap with itself: nothing to do
                        col_reg   <= col_reg + 3'd1;
                        state_reg <= (col_reg == 3'd7) ? ST_WRP : ST_COL;
                    end
                    else
                    begin
                        state_reg <= ST_SWQ;
                    end
                end
                ST_SWQ:
                begin
                    prow_reg  <= (prow_reg & ~col_mask) | (rdata_reg & col_mask);
                    col_reg   <= col_reg + 3'd1;
                    state_reg <= (col_reg == 3'd7) ? ST_WRP : ST_COL;
                end
                ST_WRP:
                begin
                    tbl_reg <= tbl_reg + 2'd1;
                    if (tbl_reg == 2'd3)
                    begin
                        row_reg <= row_reg + 8'd1;
                        if (row_reg == 8'hFF)
                        begin
                            pass_reg <= pass_reg + 3'd1;
                        end
                    end
                    if (last_unit)
                    begin
                        build_reg <= 1'b0;
                        cv_reg    <= {tcmp_pkg::IV_C, tcmp_pkg::IV_B, tcmp_pkg::IV_A};
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_UNIT;
                    end
                end
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (start_req)
                        begin
                            cv_reg <= {tcmp_pkg::IV_C, tcmp_pkg::IV_B, tcmp_pkg::IV_A};
                            ra_reg <= tcmp_pkg::IV_A;
                            rb_reg <= tcmp_pkg::IV_B;
                            rc_reg <= tcmp_pkg::IV_C;
                        end
                        else
                        begin
                            ra_reg <= cv_reg[0];
                            rb_reg <= cv_reg[1];
                            rc_reg <= cv_reg[2];
                        end
                        x_reg     <= {word7, word6, word5, word4, word3, word2, word1, word0};
                        rnd_reg   <= '0;
                        state_reg <= ST_RXOR;
                    end
                end
                ST_RXOR:
                begin
                    rc_reg    <= rc_reg ^ x_reg[rnd_reg[2:0]];
                    lk_reg    <= '0;
                    state_reg <= ST_RLOOK;
                end
                ST_RLOOK:
                begin
                    lk_reg <= lk_reg + 4'd1;
                    case (lk_reg)
                        4'd0:    acc_a_reg <= acc_a_reg;
                        4'd1:    acc_a_reg <= rdata_reg;
                        4'd2,
                        4'd3,
                        4'd4:    acc_a_reg <= acc_a_reg ^ rdata_reg;
                        4'd5:    acc_b_reg <= rdata_reg;
                        4'd6,
                        4'd7:    acc_b_reg <= acc_b_reg ^ rdata_reg;
                        default:
                        begin
                            // close the round and rotate a, b, c
                            ra_reg <= b_new;
                            rb_reg <= rc_reg;
                            rc_reg <= a_new;
                            if (rnd_reg == 5'd23)
                            begin
                                state_reg <= ST_FF;
                            end
                            else
                            begin
                                rnd_reg   <= rnd_reg + 5'd1;
                                sk_reg    <= '0;
                                state_reg <= (rnd_reg == 5'd7 || rnd_reg == 5'd15) ?
                                             ST_SCHED : ST_RXOR;
                            end
                        end
                    endcase
                end
                ST_SCHED:
                begin
                    x_reg  <= tcmp_pkg::sched_step(x_reg, sk_reg);
                    sk_reg <= sk_reg + 4'd1;
                    if (sk_reg == 4'd15)
                    begin
                        state_reg <= ST_RXOR;
                    end
                end
                ST_FF:
                begin
                    if (build_reg)
                    begin
                        cv_reg[0] <= cv_reg[0] ^ ra_reg;
                        cv_reg[1] <= rb_reg - cv_reg[1];
                        cv_reg[2] <= cv_reg[2] + rc_reg;
                        state_reg <= ST_RDP;
                    end
                    else if (out_load)
                    begin
                        // hold until the previous result has been transferred
                        cv_reg[0]     <= cv_reg[0] ^ ra_reg;
                        cv_reg[1]     <= rb_reg - cv_reg[1];
                        cv_reg[2]     <= cv_reg[2] + rc_reg;
                        hash_a_reg    <= cv_reg[0] ^ ra_reg;
                        hash_b_reg    <= rb_reg - cv_reg[1];
                        hash_c_reg    <= cv_reg[2] + rc_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
